/* rtl/tpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the tape pulse player: transaction payloads,
// command codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // Command codes carried in the mode field of an input transaction.
    localparam logic [2:0] MODE_WRITE  = 3'd0;
    localparam logic [2:0] MODE_TICK   = 3'd1;
    localparam logic [2:0] MODE_CHECK  = 3'd2;
    localparam logic [2:0] MODE_START  = 3'd3;
    localparam logic [2:0] MODE_PAUSE  = 3'd4;
    localparam logic [2:0] MODE_STOP   = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_DIRECT = 1'b0;
    localparam logic CFG_SAMPLE = 1'b1;

    // Interval constants in microseconds.
    localparam logic [25:0] PAUSED_US    = 26'd1000000;
    localparam logic [25:0] ZERO_US      = 26'd1000;
    localparam logic [25:0] GAP_US       = 26'd1500;
    localparam logic [25:0] MS_SCALE     = 26'd1000;
    localparam logic [26:0] OFFSET_US    = 27'd4;
    localparam logic [24:0] MAX_INTERVAL = 25'd32767004;

    // Bit positions inside a period word.
    localparam int PAUSE_BIT  = 15;
    localparam int DIRECT_BIT = 14;
    localparam int LEVEL_BIT  = 13;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  slot;
        logic [15:0] period;
        logic        pause_flag;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic        level;
        logic [24:0] next_interval;
        logic        interval_valid;
        logic        buffer_swapped;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/tpp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tpp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_ctrl
// Sequencing state machine: accepts one transaction, steps it through read,
// execute and finish, and waits for the output register to be free.
// ----------------------------------------------------------------------------
module tpp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output tpp_pkg::t_dp_cmd  o_cmd,
    input  tpp_pkg::t_dp_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EXEC   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_in_stall     = 1'b1;
        o_cmd.capture  = 1'b0;
        o_cmd.read     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/tpp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_datapath
// Period pages, playback state, interval arithmetic and the output register.
// Each RAM row holds one slot of both pages; a row valid bit makes a row
// that was never written since start or reset read as zero.
// ----------------------------------------------------------------------------
module tpp_datapath #(
    parameter int SLOTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpp_pkg::t_dp_cmd    i_cmd,
    output tpp_pkg::t_dp_status o_status,
    input  tpp_pkg::t_in_item   i_in_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tpp_pkg::t_out_item  o_out_data
);

    localparam int SLOT_W = $clog2(SLOTS);

    // Captured transaction and RAM address.
    tpp_pkg::t_in_item r_item;
    logic [SLOT_W-1:0] r_addr;
    logic              r_rd_valid;
    logic [SLOTS-1:0]  r_row_valid;

    // Playback state and configuration.
    logic [SLOT_W-1:0] r_read_slot;
    logic              r_active_page;
    logic              r_swap_pending;
    logic              r_paused;
    logic              r_toggle_level;
    logic              r_driven_level;
    logic              r_in_pause;
    logic              r_after_pause;
    logic              r_direct;
    logic [15:0]       r_sample_period;

    // Result staging and output register.
    logic [25:0]        r_t;
    logic               r_add_offset;
    logic               r_ival;
    logic               r_swapped;
    logic               r_out_valid;
    tpp_pkg::t_out_item r_out;

    // RAM signals.
    logic              ram_we;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_q;
    logic [31:0]       row;
    logic [15:0]       w_raw;
    logic              slot_ok;

    // Execute-step results.
    logic [SLOT_W-1:0] n_read_slot;
    logic              n_active_page;
    logic              n_swap_pending;
    logic              n_paused;
    logic              n_toggle_level;
    logic              n_driven_level;
    logic              n_in_pause;
    logic              n_after_pause;
    logic [25:0]       n_t;
    logic              n_add_offset;
    logic              n_ival;
    logic              n_swapped;
    logic              n_clear_rows;

    // Tick helpers.
    logic [15:0]       w_m;
    logic [15:0]       w_2;
    logic              tl;
    logic              flip;
    logic              do_adv;

    // Finish step.
    logic [26:0]       sum;
    logic [24:0]       interval;

    tpp_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_pages (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // Row as seen by the execute step; invalid rows read as zero.
    assign row     = r_rd_valid ? ram_q : 32'd0;
    assign w_raw   = r_active_page ? row[31:16] : row[15:0];
    assign slot_ok = (9'(r_item.slot) < 9'(SLOTS));

    // Execute step: next state, RAM write and interval term.
    always_comb begin
        n_read_slot    = r_read_slot;
        n_active_page  = r_active_page;
        n_swap_pending = r_swap_pending;
        n_paused       = r_paused;
        n_toggle_level = r_toggle_level;
        n_driven_level = r_driven_level;
        n_in_pause     = r_in_pause;
        n_after_pause  = r_after_pause;
        n_t            = 26'd0;
        n_add_offset   = 1'b0;
        n_ival         = 1'b0;
        n_swapped      = 1'b0;
        n_clear_rows   = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = row;
        w_m            = w_raw;
        w_2            = w_raw;
        tl             = r_toggle_level;
        flip           = 1'b0;
        do_adv         = 1'b0;

        unique case (r_item.mode)
            tpp_pkg::MODE_WRITE: begin
                // Store into the page that is not playing.
                ram_we = i_cmd.exec && slot_ok;
                if (r_active_page) begin
                    ram_wdata[15:0] = r_item.period;
                end else begin
                    ram_wdata[31:16] = r_item.period;
                end
            end
            tpp_pkg::MODE_TICK: begin
                n_ival       = 1'b1;
                n_add_offset = 1'b1;
                if (r_paused) begin
                    n_t = tpp_pkg::PAUSED_US;
                end else if (w_raw == 16'd0) begin
                    n_t    = tpp_pkg::ZERO_US;
                    do_adv = 1'b1;
                end else begin
                    // Level toggling and pause tracking.
                    if (w_raw[tpp_pkg::PAUSE_BIT]) begin
                        n_in_pause    = 1'b1;
                        w_m           = {1'b0, w_raw[14:0]};
                        tl            = ~r_toggle_level;
                        flip          = 1'b1;
                        n_after_pause = 1'b1;
                    end else if (!r_after_pause) begin
                        tl = ~r_toggle_level;
                    end else if (!r_in_pause) begin
                        n_after_pause = 1'b0;
                    end
                    n_toggle_level = tl;

                    // Direct recording overrides level and interval.
                    if (r_direct && w_m[tpp_pkg::DIRECT_BIT]) begin
                        n_driven_level = w_m[tpp_pkg::LEVEL_BIT];
                        w_2            = r_sample_period;
                    end else begin
                        n_driven_level = tl;
                        w_2            = w_m;
                    end

                    if (flip) begin
                        // Rewrite the entry as its pause length minus one.
                        n_toggle_level = 1'b0;
                        n_t            = tpp_pkg::GAP_US;
                        ram_we         = i_cmd.exec;
                        if (r_active_page) begin
                            ram_wdata[31:16] = w_2 - 16'd1;
                        end else begin
                            ram_wdata[15:0] = w_2 - 16'd1;
                        end
                    end else if (r_in_pause) begin
                        n_t        = 26'(w_2) * tpp_pkg::MS_SCALE;
                        n_in_pause = 1'b0;
                        do_adv     = 1'b1;
                    end else begin
                        n_t    = 26'(w_2);
                        do_adv = 1'b1;
                    end
                end

                // Slot advance with page swap at the end of a page.
                if (do_adv) begin
                    if (r_read_slot == SLOT_W'(SLOTS - 1)) begin
                        n_read_slot    = '0;
                        n_active_page  = ~r_active_page;
                        n_swap_pending = 1'b1;
                    end else begin
                        n_read_slot = r_read_slot + SLOT_W'(1);
                    end
                end
            end
            tpp_pkg::MODE_CHECK: begin
                n_swapped      = r_swap_pending;
                n_swap_pending = 1'b0;
            end
            tpp_pkg::MODE_START: begin
                n_toggle_level = 1'b0;
                n_paused       = 1'b0;
                n_driven_level = 1'b0;
                n_clear_rows   = 1'b1;
                n_t            = 26'(r_item.period);
                n_ival         = 1'b1;
            end
            tpp_pkg::MODE_PAUSE: begin
                n_paused = r_item.pause_flag;
            end
            tpp_pkg::MODE_STOP: begin
                n_paused = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Finish step: for ticks, add the timer offset and saturate; else pass the term through.
    assign sum = {1'b0, r_t} + tpp_pkg::OFFSET_US;
    always_comb begin
        if (!r_add_offset) begin
            interval = 25'(r_t);
        end else if (sum > 27'(tpp_pkg::MAX_INTERVAL)) begin
            interval = tpp_pkg::MAX_INTERVAL;
        end else begin
            interval = 25'(sum);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid     <= '0;
            r_read_slot     <= '0;
            r_active_page   <= 1'b0;
            r_swap_pending  <= 1'b1;
            r_paused        <= 1'b1;
            r_toggle_level  <= 1'b0;
            r_driven_level  <= 1'b0;
            r_in_pause      <= 1'b0;
            r_after_pause   <= 1'b0;
            r_direct        <= 1'b0;
            r_sample_period <= 16'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == tpp_pkg::CFG_DIRECT) begin
                    r_direct <= i_cfg_data[0];
                end else begin
                    r_sample_period <= i_cfg_data;
                end
            end
            if (i_cmd.exec) begin
                r_read_slot    <= n_read_slot;
                r_active_page  <= n_active_page;
                r_swap_pending <= n_swap_pending;
                r_paused       <= n_paused;
                r_toggle_level <= n_toggle_level;
                r_driven_level <= n_driven_level;
                r_in_pause     <= n_in_pause;
                r_after_pause  <= n_after_pause;
                if (n_clear_rows) begin
                    r_row_valid <= '0;
                end else if (ram_we) begin
                    r_row_valid[r_addr] <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
            r_addr <= (i_in_data.mode == tpp_pkg::MODE_WRITE) ?
                      SLOT_W'(i_in_data.slot) : r_read_slot;
        end
        if (i_cmd.read) begin
            r_rd_valid <= r_row_valid[r_addr];
        end
        if (i_cmd.exec) begin
            r_t          <= n_t;
            r_add_offset <= n_add_offset;
            r_ival       <= n_ival;
            r_swapped    <= n_swapped;
        end
        if (i_cmd.load_out) begin
            r_out.level          <= r_driven_level;
            r_out.next_interval  <= interval;
            r_out.interval_valid <= r_ival;
            r_out.buffer_swapped <= r_swapped;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

/* rtl/tape_pulse_player.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_pulse_player
// Double-buffered pulse-train generator for tape playback.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_stall    i_in_data  (tpp_pkg::t_in_item)
//   output   o_out_valid / i_out_stall  o_out_data (tpp_pkg::t_out_item)
//   config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Every transaction steps through capture, page RAM read, execute
// (state update, RAM write-back, multiply) and finish (offset and saturate).
// The registered RAM read has its own step; one transaction is in work at once.
// A stalled output holds the finish step until the output register frees.
// Reset and start clear all rows at once through per-row valid bits, with no
// clearing pass. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module tape_pulse_player #(
    parameter int SLOTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tpp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpp_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    tpp_pkg::t_dp_cmd    cmd;
    tpp_pkg::t_dp_status status;

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    tpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    tpp_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
